// ===== rtl/core/gtc_pkg.sv =====
package gtc_pkg;

    // default geometry
    localparam int WAYS_DEF      = 8;
    localparam int MAX_SETS_DEF  = 8;
    localparam int FRAC_BITS     = 4;

    // field widths
    localparam int CODE_W        = 16;
    localparam int FRAC_W        = 4;
    localparam int KEY_W         = CODE_W + 2 * FRAC_W;
    localparam int MET_W         = 42;
    localparam int DIM_W         = 10;
    localparam int SLOT_W        = 6;
    localparam int IN_DATA_W     = 72;
    localparam int IN_USER_W     = 1;
    localparam int OUT_DATA_W    = 48;
    localparam int OUT_USER_W    = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 10;

    localparam logic [FRAC_W-1:0] FRAC_MASK = FRAC_W'((1 << FRAC_BITS) - 1);

    // fractions are dropped above this box height
    localparam logic [DIM_W-1:0] FRAC_MAX_HEIGHT = DIM_W'(50);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CACHE_EN   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ANTI_ALIAS = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = CFG_IDX_W'(4);

    // register reset values
    localparam logic [DIM_W-1:0] BOX_RESET      = DIM_W'(1000);
    localparam logic [1:0]       SET_BITS_RESET = 2'd3;

    // function codes
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_FILL   = 1'b1;

    typedef struct packed {
        logic load;
        logic cmp;
        logic upd;
        logic out_load;
    } t_cmd;

endpackage

// ===== rtl/core/gtc_ctrl.sv =====
module gtc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output gtc_pkg::t_cmd o_cmd
);
    import gtc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = i_in_valid && (r_state == S_IDLE);
        o_cmd.cmp      = (r_state == S_LOOK);
        o_cmd.upd      = (r_state == S_UPD);
        o_cmd.out_load = (r_state == S_OUT) && out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_LOOK;
            end
            S_LOOK: n_state = S_UPD;
            S_UPD:  n_state = S_OUT;
            S_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/core/gtc_datapath.sv =====
module gtc_datapath #(
    parameter int WAYS     = gtc_pkg::WAYS_DEF,
    parameter int MAX_SETS = gtc_pkg::MAX_SETS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  gtc_pkg::t_cmd                    i_cmd,
    input  logic                             i_cfg_we,
    input  logic [gtc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gtc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [gtc_pkg::IN_USER_W-1:0]    i_in_user,
    input  logic [gtc_pkg::IN_DATA_W-1:0]    i_in_data,
    output logic [gtc_pkg::OUT_USER_W-1:0]   o_out_user,
    output logic [gtc_pkg::OUT_DATA_W-1:0]   o_out_data
);
    import gtc_pkg::*;

    localparam int AGE_W   = $clog2(WAYS);
    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int ENTRIES = MAX_SETS * WAYS;
    localparam int ENT_W   = $clog2(ENTRIES);
    localparam logic [AGE_W-1:0] MAX_AGE = AGE_W'(WAYS - 1);

    // configuration
    logic              r_cache_en;
    logic              r_anti_alias;
    logic [1:0]        r_set_bits;
    logic [DIM_W-1:0]  r_box_w;
    logic [DIM_W-1:0]  r_box_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_en   <= 1'b1;
            r_anti_alias <= 1'b1;
            r_set_bits   <= SET_BITS_RESET;
            r_box_w      <= BOX_RESET;
            r_box_h      <= BOX_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CACHE_EN:   r_cache_en   <= i_cfg_data[0];
                REG_ANTI_ALIAS: r_anti_alias <= i_cfg_data[0];
                REG_SET_BITS:   r_set_bits   <= i_cfg_data[1:0];
                REG_BOX_WIDTH:  r_box_w      <= i_cfg_data;
                REG_BOX_HEIGHT: r_box_h      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // incoming item fields
    logic [CODE_W-1:0] in_code;
    logic [FRAC_W-1:0] in_xf;
    logic [FRAC_W-1:0] in_yf;
    logic [MET_W-1:0]  in_metrics;
    logic [DIM_W-1:0]  in_w;
    logic [DIM_W-1:0]  in_h;
    logic              frac_on;
    logic [KEY_W-1:0]  in_key;
    logic [2:0]        set_mask;
    logic [6:0]        set_tmp;
    logic [SET_W-1:0]  in_set;
    logic              in_fits;

    assign in_code    = i_in_data[15:0];
    assign in_xf      = i_in_data[19:16];
    assign in_yf      = i_in_data[23:20];
    assign in_metrics = i_in_data[65:24];
    assign in_w       = i_in_data[55:46];
    assign in_h       = i_in_data[65:56];

    assign frac_on  = r_anti_alias && (r_box_h <= FRAC_MAX_HEIGHT);
    assign in_key   = {frac_on ? (in_yf & FRAC_MASK) : {FRAC_W{1'b0}},
                       frac_on ? (in_xf & FRAC_MASK) : {FRAC_W{1'b0}},
                       in_code};
    assign set_mask = 3'((4'd1 << r_set_bits) - 4'd1);
    assign in_fits  = r_cache_en && (in_w <= r_box_w) && (in_h <= r_box_h);

    // fold the masked code into the stored sets, at most seven subtractions
    always_comb begin
        set_tmp = {4'd0, in_code[2:0] & set_mask};
        for (int k = 0; k < 8; k++) begin
            if (set_tmp >= 7'(MAX_SETS)) set_tmp = set_tmp - 7'(MAX_SETS);
        end
        in_set = SET_W'(set_tmp);
    end

    // item registers
    logic              r_func;
    logic [KEY_W-1:0]  r_key;
    logic [SET_W-1:0]  r_set;
    logic [MET_W-1:0]  r_metrics;
    logic              r_fits;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func    <= i_in_user[0];
            r_key     <= in_key;
            r_set     <= in_set;
            r_metrics <= in_metrics;
            r_fits    <= in_fits;
        end
    end

    // per-entry valid bits and per-set age-written marks
    logic [WAYS-1:0]     r_valid [MAX_SETS];
    logic [MAX_SETS-1:0] r_age_ok;

    // stage registers
    logic [WAYS*KEY_W-1:0]  r_key_row;
    logic [WAYS*AGE_W-1:0]  r_age_raw;
    logic [AGE_W-1:0]       r_ages [WAYS];
    logic                   r_hit;
    logic                   r_store;
    logic                   r_age_we;
    logic [AGE_W-1:0]       r_way;
    logic [MET_W-1:0]       r_met_rd;
    logic                   r_res_hit;
    logic                   r_res_cached;
    logic [SLOT_W-1:0]      r_res_slot;
    logic [OUT_DATA_W-1:0]  r_out_data;
    logic [OUT_USER_W-1:0]  r_out_user;

    // memories
    logic [WAYS*KEY_W-1:0] key_mem [MAX_SETS];
    logic [WAYS*AGE_W-1:0] age_mem [MAX_SETS];
    logic [MET_W-1:0]      met_mem [ENTRIES];

    // compare stage
    logic [AGE_W-1:0] ages_eff [WAYS];
    logic             hit_any;
    logic [AGE_W-1:0] hit_way;
    logic             vic_any;
    logic [AGE_W-1:0] vic_way;

    always_comb begin
        hit_any = 1'b0;
        hit_way = '0;
        vic_any = 1'b0;
        vic_way = '0;
        for (int w = 0; w < WAYS; w++) begin
            ages_eff[w] = r_age_ok[r_set] ? r_age_raw[w*AGE_W +: AGE_W] : AGE_W'(w);
            if (!hit_any && r_valid[r_set][w] &&
                (r_key_row[w*KEY_W +: KEY_W] == r_key)) begin
                hit_any = 1'b1;
                hit_way = AGE_W'(w);
            end
            if (!vic_any && (ages_eff[w] == MAX_AGE)) begin
                vic_any = 1'b1;
                vic_way = AGE_W'(w);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_ages   <= ages_eff;
            r_hit    <= (r_func == FUNC_LOOKUP) && r_cache_en && hit_any;
            r_store  <= (r_func == FUNC_FILL) && r_fits && vic_any;
            r_age_we <= ((r_func == FUNC_LOOKUP) && r_cache_en && hit_any) ||
                        ((r_func == FUNC_FILL) && r_fits);
            r_way    <= (r_func == FUNC_FILL) ? vic_way : hit_way;
        end
    end

    // update stage
    logic [AGE_W-1:0]      hit_age;
    logic [WAYS*AGE_W-1:0] age_row_new;
    logic [WAYS*KEY_W-1:0] key_row_new;
    logic [ENT_W-1:0]      entry;

    assign hit_age = r_ages[r_way];
    assign entry   = ENT_W'(int'(r_set) * WAYS + int'(r_way));

    always_comb begin
        age_row_new = '0;
        key_row_new = r_key_row;
        for (int w = 0; w < WAYS; w++) begin
            if (r_func == FUNC_FILL) begin
                if ((AGE_W'(w) == r_way) && r_store) begin
                    age_row_new[w*AGE_W +: AGE_W] = '0;
                end else if (r_ages[w] < MAX_AGE) begin
                    age_row_new[w*AGE_W +: AGE_W] = r_ages[w] + AGE_W'(1);
                end else begin
                    age_row_new[w*AGE_W +: AGE_W] = r_ages[w];
                end
            end else begin
                if (AGE_W'(w) == r_way) begin
                    age_row_new[w*AGE_W +: AGE_W] = '0;
                end else if (r_ages[w] < hit_age) begin
                    age_row_new[w*AGE_W +: AGE_W] = r_ages[w] + AGE_W'(1);
                end else begin
                    age_row_new[w*AGE_W +: AGE_W] = r_ages[w];
                end
            end
            if (AGE_W'(w) == r_way) key_row_new[w*KEY_W +: KEY_W] = r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_key_row <= key_mem[in_set];
        if (i_cmd.upd && r_store) key_mem[r_set] <= key_row_new;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_age_raw <= age_mem[in_set];
        if (i_cmd.upd && r_age_we) age_mem[r_set] <= age_row_new;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_met_rd <= met_mem[entry];
            if (r_store) met_mem[entry] <= r_metrics;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < MAX_SETS; s++) r_valid[s] <= '0;
            r_age_ok <= '0;
        end else if (i_cmd.upd) begin
            if (r_store)  r_valid[r_set][r_way] <= 1'b1;
            if (r_age_we) r_age_ok[r_set]       <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_res_hit    <= r_hit;
            r_res_cached <= r_store;
            r_res_slot   <= (r_hit || r_store) ? SLOT_W'(entry) : '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {r_res_hit ? r_met_rd : {MET_W{1'b0}}, r_res_slot};
            r_out_user <= {r_res_cached, r_res_hit};
        end
    end

    assign o_out_data = r_out_data;
    assign o_out_user = r_out_user;

endmodule

// ===== rtl/core/glyph_tag_cache_lru_unit.sv =====
// sequencing: an input transaction is taken with the row read, and its result transaction follows
// the output load, later while the output is stalled
// the four-step sequencer (row read, tag compare, row update with metrics read, output load)
// works on one item at a time and takes no new item until the last one is through
// reset: synchronous active-low i_rst_n; clears all entry valid bits and per-set age marks
// at once, so every set reads as empty with ages equal to the way number; no clearing pass
module glyph_tag_cache_lru_unit #(
    parameter int WAYS     = gtc_pkg::WAYS_DEF,
    parameter int MAX_SETS = gtc_pkg::MAX_SETS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [15:0] char_code, [19:16] x_frac, [23:20] y_frac, [34:24] fill_x,
    // [45:35] fill_y, [55:46] fill_w, [65:56] fill_h, [71:66] zero
    input  logic [gtc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [0] func
    input  logic [gtc_pkg::IN_USER_W-1:0]   s_axis_tuser,

    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [5:0] slot, [16:6] glyph_x, [27:17] glyph_y, [37:28] glyph_w, [47:38] glyph_h
    output logic [gtc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // [0] hit, [1] cached
    output logic [gtc_pkg::OUT_USER_W-1:0]  m_axis_tuser,

    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gtc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gtc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import gtc_pkg::*;

    t_cmd cmd;

    // always writable; user changes registers only while unit is idle, block does not enforce it
    assign o_cfg_ready = 1'b1;

    // sequencer: accepts a transaction in idle, steps through compare and
    // update, then holds in the output step until the result register is free
    gtc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    // tag, age and metrics storage, key build, way compare and lru aging
    gtc_datapath #(
        .WAYS     (WAYS),
        .MAX_SETS (MAX_SETS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_user   (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_out_data  (m_axis_tdata)
    );

endmodule
